@@ rtl/branch_and_address_reloc_patcher_core_defines.svh @@
// ----------------------------------------------------------------------------
// relocation patcher assertion macros
// property shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef BRANCH_AND_ADDRESS_RELOC_PATCHER_CORE_DEFINES_SVH
`define BRANCH_AND_ADDRESS_RELOC_PATCHER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define BARP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define BARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs during reset
`define BARP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/barp_pkg.sv @@
// ----------------------------------------------------------------------------
// relocation patcher package
// opcode constants, codes and request/result types
// ----------------------------------------------------------------------------
`default_nettype none

package barp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 64;

  // full instruction templates
  localparam logic [31:0] INSN_PCADDU18I = 32'h1e000000;
  localparam logic [31:0] INSN_JIRL      = 32'h4c000000;
  localparam logic [31:0] INSN_B         = 32'h50000000;
  localparam logic [31:0] INSN_BL        = 32'h54000000;
  localparam logic [31:0] INSN_BEQ       = 32'h58000000;
  localparam logic [31:0] INSN_BGEU      = 32'h6c000000;
  localparam logic [31:0] INSN_BEQZ      = 32'h40000000;
  localparam logic [31:0] INSN_BNEZ      = 32'h44000000;
  localparam logic [31:0] INSN_BCXXZ     = 32'h48000000;
  localparam logic [31:0] INSN_LU12I_W   = 32'h14000000;
  localparam logic [31:0] INSN_ORI       = 32'h03800000;
  localparam logic [31:0] INSN_LU32I_D   = 32'h16000000;

  // major opcode fields, bits 31..26
  localparam logic [5:0] OP_B     = INSN_B[31:26];
  localparam logic [5:0] OP_BL    = INSN_BL[31:26];
  localparam logic [5:0] OP_CMP_LO = INSN_BEQ[31:26];
  localparam logic [5:0] OP_CMP_HI = INSN_BGEU[31:26];
  localparam logic [5:0] OP_BEQZ  = INSN_BEQZ[31:26];
  localparam logic [5:0] OP_BNEZ  = INSN_BNEZ[31:26];
  localparam logic [5:0] OP_BCXXZ = INSN_BCXXZ[31:26];

  // constant-load opcode fields
  localparam logic [6:0] OP_LU12I_W = INSN_LU12I_W[31:25];
  localparam logic [9:0] OP_ORI     = INSN_ORI[31:22];
  localparam logic [6:0] OP_LU32I_D = INSN_LU32I_D[31:25];

  // scratch register used by the pc-relative pair
  localparam logic [4:0] SCRATCH_REG = 5'd12;

  typedef enum logic [1:0] {
    MODE_BRANCH = 2'd0,
    MODE_PCREL  = 2'd1,
    MODE_ABS2   = 2'd2,
    MODE_ABS3   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_ENCODING = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [ADDR_W-1:0]  patch_pc;
    logic [ADDR_W-1:0]  target;
    logic [WORD_W-1:0]  word0;
    logic [WORD_W-1:0]  word1;
    logic [WORD_W-1:0]  word2;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word0;
    logic [WORD_W-1:0]  word1;
    logic [WORD_W-1:0]  word2;
    status_t            status;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/barp_patch.sv @@
// ----------------------------------------------------------------------------
// relocation patch logic
// rewrites one request's instruction words to reach its target
// ----------------------------------------------------------------------------
`default_nettype none

module barp_patch (
  input  wire barp_pkg::req_t req,
  output barp_pkg::res_t      res
);

  logic [63:0] diff;
  logic [45:0] up_sum;
  logic        misaligned;
  logic        fit26;
  logic        fit16;
  logic        fit21;
  logic        fit_up;
  logic [5:0]  op;
  logic [31:0] pw0;
  logic [31:0] pw1;
  logic [31:0] pw2;
  barp_pkg::status_t st;

  // word offset is diff[63:2]; range checks look at the sign-extension bits
  assign diff       = req.target - req.patch_pc;
  assign misaligned = |diff[1:0];
  assign fit26      = (&diff[63:27]) | ~(|diff[63:27]);
  assign fit16      = (&diff[63:17]) | ~(|diff[63:17]);
  assign fit21      = (&diff[63:22]) | ~(|diff[63:22]);

  // upper part of the pair: (offset + 2^15) >> 16, rounded by offset bit 15
  assign up_sum = diff[63:18] + {45'd0, diff[17]};
  assign fit_up = (&up_sum[45:19]) | ~(|up_sum[45:19]);

  assign op = req.word0[31:26];

  always_comb begin
    pw0 = req.word0;
    pw1 = req.word1;
    pw2 = req.word2;
    st  = barp_pkg::ST_OK;
    unique case (req.mode)
      barp_pkg::MODE_BRANCH: begin
        if (misaligned) begin
          st = barp_pkg::ST_RANGE;
        end else if (op == barp_pkg::OP_B || op == barp_pkg::OP_BL) begin
          if (!fit26) st = barp_pkg::ST_RANGE;
          pw0 = {op, diff[17:2], diff[27:18]};
        end else if (op >= barp_pkg::OP_CMP_LO && op <= barp_pkg::OP_CMP_HI) begin
          if (!fit16) st = barp_pkg::ST_RANGE;
          pw0 = {op, diff[17:2], req.word0[9:0]};
        end else if (op == barp_pkg::OP_BEQZ || op == barp_pkg::OP_BNEZ ||
                     op == barp_pkg::OP_BCXXZ) begin
          if (!fit21) st = barp_pkg::ST_RANGE;
          pw0 = {op, diff[17:2], req.word0[9:5], diff[22:18]};
        end else begin
          st = barp_pkg::ST_ENCODING;
        end
      end
      barp_pkg::MODE_PCREL: begin
        if (misaligned || !fit_up) st = barp_pkg::ST_RANGE;
        pw0 = {barp_pkg::INSN_PCADDU18I[31:25], up_sum[19:0], barp_pkg::SCRATCH_REG};
        pw1 = {barp_pkg::INSN_JIRL[31:26], diff[17:2], barp_pkg::SCRATCH_REG,
               req.word1[4:0]};
      end
      barp_pkg::MODE_ABS2, barp_pkg::MODE_ABS3: begin
        if (req.mode == barp_pkg::MODE_ABS2 && (|req.target[63:31])) begin
          st = barp_pkg::ST_RANGE;
        end else if (req.word0[31:25] != barp_pkg::OP_LU12I_W ||
                     req.word1[31:22] != barp_pkg::OP_ORI ||
                     (req.mode == barp_pkg::MODE_ABS3 &&
                      req.word2[31:25] != barp_pkg::OP_LU32I_D)) begin
          st = barp_pkg::ST_ENCODING;
        end
        pw0 = {req.word0[31:25], req.target[31:12], req.word0[4:0]};
        pw1 = {req.word1[31:22], req.target[11:0], req.word1[9:0]};
        if (req.mode == barp_pkg::MODE_ABS3) begin
          pw2 = {req.word2[31:25], req.target[51:32], req.word2[4:0]};
        end
      end
      default: begin
        st = barp_pkg::ST_ENCODING;
      end
    endcase
    // any error hands the original words back
    if (st != barp_pkg::ST_OK) begin
      pw0 = req.word0;
      pw1 = req.word1;
      pw2 = req.word2;
    end
  end

  assign res.word0  = pw0;
  assign res.word1  = pw1;
  assign res.word2  = pw2;
  assign res.status = st;

endmodule

`default_nettype wire

@@ rtl/branch_and_address_reloc_patcher_core.sv @@
// ----------------------------------------------------------------------------
// branch and address relocation patcher, top level
// Requests arrive on the in_ stream: in_tuser carries the mode, in_tdata the
// patch address, target and three instruction words. Each request gives one
// result on the out_ stream: three words in out_tdata and a status in
// out_tuser (ok, misaligned or out of range, unknown encoding). On error
// the words come back unchanged.
// A request passes through one input register, then the patch logic (a
// 64-bit subtract and a short increment) feeding the result register.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more; in_tready drops only once both
// are full. Synchronous reset clears both valid flags, so nothing is
// pending after reset and in_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module branch_and_address_reloc_patcher_core (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // patch_pc [63:0], target [127:64], word0 [159:128],
  // word1 [191:160], word2 [223:192]
  input  wire  [223:0] in_tdata,
  // mode [1:0]
  input  wire  [1:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // word0 [31:0], word1 [63:32], word2 [95:64]
  output logic [95:0]  out_tdata,
  // status [1:0]
  output logic [1:0]   out_tuser
);

  logic           req_valid_r;
  logic           req_valid_nxt;
  barp_pkg::req_t req_r;
  logic           res_valid_r;
  logic           res_valid_nxt;
  barp_pkg::res_t res_r;
  barp_pkg::res_t res_calc;
  logic           advance;
  logic           in_fire;

  assign advance   = !res_valid_r || out_tready;
  assign in_tready = !req_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign req_valid_nxt = in_fire || (req_valid_r && !advance);
  assign res_valid_nxt = advance ? req_valid_r : res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.mode     <= barp_pkg::mode_t'(in_tuser);
      req_r.patch_pc <= in_tdata[63:0];
      req_r.target   <= in_tdata[127:64];
      req_r.word0    <= in_tdata[159:128];
      req_r.word1    <= in_tdata[191:160];
      req_r.word2    <= in_tdata[223:192];
    end
    if (advance && req_valid_r) begin
      res_r <= res_calc;
    end
  end

  barp_patch u_patch (
    .req (req_r),
    .res (res_calc)
  );

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {res_r.word2, res_r.word1, res_r.word0};
  assign out_tuser  = res_r.status;

endmodule

`default_nettype wire

@@ rtl/barp_checker.sv @@
// ----------------------------------------------------------------------------
// relocation patcher port checker
// watches the top level's streams and binds to every instance of it
// ----------------------------------------------------------------------------
`default_nettype none

`include "branch_and_address_reloc_patcher_core_defines.svh"

module barp_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [95:0]  out_tdata,
  input wire [1:0]   out_tuser
);

  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  // a stalled result keeps its value
  `BARP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // nothing pending right after reset
  `BARP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid && in_tready, "result or back-pressure right after reset")

  // a fresh result comes from a request accepted into the input register, then moved to the result register
  `BARP_ASSERT_SAME(a_latency, clk, rst_n, $rose(out_tvalid), $past(in_fire, 2), "result without a request two cycles before")

  // back-pressure only when the output side is stalled
  `BARP_ASSERT_SAME(a_ready_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled while output free")

endmodule

bind branch_and_address_reloc_patcher_core barp_checker u_barp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relocation patcher testbench
// Streams branch, pc-relative and constant-load requests through the core
// with random gaps on both sides and checks every result, word by word and
// status, against an in-order queue filled by a behavioral patch predictor.
// ----------------------------------------------------------------------------

module tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  barp_pkg::req_t pending_requests[$];
  barp_pkg::res_t expected_patches[$];
  int   mismatches = 0;
  int   in_wait = 0;
  int   out_wait = 0;
  bit   in_quiet = 1'b0;
  bit   out_quiet = 1'b0;

  branch_and_address_reloc_patcher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic bit fits_signed(logic signed [63:0] v, int n);
    return ((v >>> n) == 0) || ((v >>> n) == -1);
  endfunction

  // expected words and status for one patch request
  function automatic barp_pkg::res_t patch_words(barp_pkg::req_t r);
    logic [63:0]        byte_dist;
    logic signed [63:0] off;
    logic signed [63:0] up;
    logic [5:0]         op;
    barp_pkg::res_t     res;
    byte_dist = r.target - r.patch_pc;
    off = $signed(byte_dist) >>> 2;
    up = (off + 64'sd32768) >>> 16;
    op = r.word0[31:26];
    res.word0 = r.word0;
    res.word1 = r.word1;
    res.word2 = r.word2;
    res.status = barp_pkg::ST_OK;
    case (r.mode)
      barp_pkg::MODE_BRANCH: begin
        // alignment is checked ahead of the opcode
        if (byte_dist[1:0] != 2'b00) begin
          res.status = barp_pkg::ST_RANGE;
        end else if (op == barp_pkg::OP_B || op == barp_pkg::OP_BL) begin
          if (!fits_signed(off, 25)) res.status = barp_pkg::ST_RANGE;
          else res.word0 = {op, off[15:0], off[25:16]};
        end else if (op >= barp_pkg::OP_CMP_LO && op <= barp_pkg::OP_CMP_HI) begin
          if (!fits_signed(off, 15)) res.status = barp_pkg::ST_RANGE;
          else res.word0 = {op, off[15:0], r.word0[9:0]};
        end else if (op == barp_pkg::OP_BEQZ || op == barp_pkg::OP_BNEZ ||
                     op == barp_pkg::OP_BCXXZ) begin
          if (!fits_signed(off, 20)) res.status = barp_pkg::ST_RANGE;
          else res.word0 = {op, off[15:0], r.word0[9:5], off[20:16]};
        end else begin
          res.status = barp_pkg::ST_ENCODING;
        end
      end
      barp_pkg::MODE_PCREL: begin
        if (byte_dist[1:0] != 2'b00 || !fits_signed(up, 19)) begin
          res.status = barp_pkg::ST_RANGE;
        end else begin
          res.word0 = barp_pkg::INSN_PCADDU18I | {up[19:0], barp_pkg::SCRATCH_REG};
          res.word1 = barp_pkg::INSN_JIRL |
                      {off[15:0], barp_pkg::SCRATCH_REG, r.word1[4:0]};
        end
      end
      barp_pkg::MODE_ABS2, barp_pkg::MODE_ABS3: begin
        if (r.mode == barp_pkg::MODE_ABS2 && r.target[63:31] != '0) begin
          res.status = barp_pkg::ST_RANGE;
        end else if (r.word0[31:25] != barp_pkg::OP_LU12I_W ||
                     r.word1[31:22] != barp_pkg::OP_ORI ||
                     (r.mode == barp_pkg::MODE_ABS3 &&
                      r.word2[31:25] != barp_pkg::OP_LU32I_D)) begin
          res.status = barp_pkg::ST_ENCODING;
        end else begin
          res.word0 = {r.word0[31:25], r.target[31:12], r.word0[4:0]};
          res.word1 = {r.word1[31:22], r.target[11:0], r.word1[9:0]};
          if (r.mode == barp_pkg::MODE_ABS3)
            res.word2 = {r.word2[31:25], r.target[51:32], r.word2[4:0]};
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // byte distance, mostly within +-2^lim words, some on the range edges
  function automatic logic [63:0] rand_distance(int lim, longint bias);
    logic [63:0]        raw;
    logic signed [63:0] v;
    logic signed [63:0] bound;
    logic [63:0]        d;
    int                 w;
    raw = rand64();
    case ($urandom_range(0, 9))
      7, 8: begin
        bound = 64'sd1 <<< lim;
        if ($urandom_range(0, 1) == 1) bound = -bound;
        v = bound - bias + $urandom_range(0, 6) - 3;
      end
      9: v = raw;
      default: begin
        w = $urandom_range(0, lim);
        v = $signed(raw << (63 - w)) >>> (63 - w);
      end
    endcase
    d = v <<< 2;
    if ($urandom_range(0, 7) == 0) d = d + $urandom_range(1, 3);
    return d;
  endfunction

  function automatic barp_pkg::req_t random_request();
    barp_pkg::req_t r;
    logic [5:0]     op;
    int             lim;
    r.mode = barp_pkg::mode_t'($urandom_range(0, 3));
    r.patch_pc = rand64();
    r.target = rand64();
    r.word0 = $urandom;
    r.word1 = $urandom;
    r.word2 = $urandom;
    // plain noise
    if ($urandom_range(0, 9) == 0) return r;
    case (r.mode)
      barp_pkg::MODE_BRANCH: begin
        case ($urandom_range(0, 7))
          0: op = barp_pkg::OP_B;
          1: op = barp_pkg::OP_BL;
          2: op = 6'($urandom_range(barp_pkg::OP_CMP_LO, barp_pkg::OP_CMP_HI));
          3: op = barp_pkg::OP_BEQZ;
          4: op = barp_pkg::OP_BNEZ;
          5: op = barp_pkg::OP_BCXXZ;
          default: op = 6'($urandom);
        endcase
        if (op >= barp_pkg::OP_CMP_LO && op <= barp_pkg::OP_CMP_HI) lim = 15;
        else if (op == barp_pkg::OP_BEQZ || op == barp_pkg::OP_BNEZ ||
                 op == barp_pkg::OP_BCXXZ) lim = 20;
        else lim = 25;
        r.word0 = {op, r.word0[25:0]};
        r.target = r.patch_pc + rand_distance(lim, 0);
      end
      barp_pkg::MODE_PCREL: begin
        r.target = r.patch_pc + rand_distance(35, 32768);
      end
      barp_pkg::MODE_ABS2, barp_pkg::MODE_ABS3: begin
        r.word0 = {barp_pkg::OP_LU12I_W, r.word0[24:0]};
        r.word1 = {barp_pkg::OP_ORI, r.word1[21:0]};
        r.word2 = {barp_pkg::OP_LU32I_D, r.word2[24:0]};
        if (r.mode == barp_pkg::MODE_ABS2) begin
          case ($urandom_range(0, 3))
            0, 1: r.target = {33'b0, r.target[30:0]};
            2: r.target = 64'h7fff_fffe + $urandom_range(0, 3);
            default: ;
          endcase
        end
        // broken encoding in one of the opcode fields
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 2))
            0: r.word0 = r.word0 ^ (32'h1 << (25 + $urandom_range(0, 6)));
            1: r.word1 = r.word1 ^ (32'h1 << (22 + $urandom_range(0, 9)));
            default: r.word2 = r.word2 ^ (32'h1 << (25 + $urandom_range(0, 6)));
          endcase
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_request(barp_pkg::mode_t m, logic [63:0] pa, logic [63:0] tg,
                             logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
    barp_pkg::req_t r;
    r.mode = m;
    r.patch_pc = pa;
    r.target = tg;
    r.word0 = w0;
    r.word1 = w1;
    r.word2 = w2;
    pending_requests.push_back(r);
  endtask

  task automatic add_jump(barp_pkg::mode_t m, logic [63:0] pa, logic signed [63:0] off,
                          logic [31:0] w0);
    add_request(m, pa, pa + (off <<< 2), w0, $urandom, $urandom);
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // request driver
  always @(posedge clk) begin
    barp_pkg::req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        r = pending_requests.pop_front();
        in_tdata <= {r.word2, r.word1, r.word0, r.target, r.patch_pc};
        in_tuser <= r.mode;
        in_tvalid <= 1'b1;
        expected_patches.push_back(patch_words(r));
        if ($urandom_range(0, 63) == 0) in_quiet = !in_quiet;
        in_wait = in_quiet ? 0 : $urandom_range(0, 19);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    barp_pkg::res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_patches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %h status %0d", out_tdata, out_tuser);
        end else begin
          want = expected_patches.pop_front();
          if (out_tdata[31:0] != want.word0) note_mismatch("word0", want.word0, out_tdata[31:0]);
          if (out_tdata[63:32] != want.word1) note_mismatch("word1", want.word1, out_tdata[63:32]);
          if (out_tdata[95:64] != want.word2) note_mismatch("word2", want.word2, out_tdata[95:64]);
          if (out_tuser != want.status) note_mismatch("status", want.status, out_tuser);
        end
        if ($urandom_range(0, 63) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 19);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    // branch offsets at and past each range edge
    add_jump(barp_pkg::MODE_BRANCH, 64'h0000_0000_0000_1000, 64'sd33554431,
             barp_pkg::INSN_B | 32'h03ff_ffff);
    add_jump(barp_pkg::MODE_BRANCH, 64'h8000_0000_0000_0000, -64'sd33554432,
             barp_pkg::INSN_BL);
    add_jump(barp_pkg::MODE_BRANCH, 64'h0000_0000_4000_0000, 64'sd33554432,
             barp_pkg::INSN_B);
    add_jump(barp_pkg::MODE_BRANCH, 64'h0000_0000_0010_0000, -64'sd32768,
             barp_pkg::INSN_BEQ | 32'h03ff_ffff);
    add_jump(barp_pkg::MODE_BRANCH, 64'h0000_0000_0010_0000, 64'sd32768,
             barp_pkg::INSN_BGEU);
    add_jump(barp_pkg::MODE_BRANCH, 64'h0000_1234_0000_0000, 64'sd1048575,
             barp_pkg::INSN_BEQZ | 32'h0000_03ff);
    add_jump(barp_pkg::MODE_BRANCH, 64'h0000_1234_0000_0000, -64'sd1048577,
             barp_pkg::INSN_BNEZ);
    add_jump(barp_pkg::MODE_BRANCH, 64'hffff_0000_0000_0000, -64'sd1048576,
             barp_pkg::INSN_BCXXZ | 32'h0000_0100);
    // unknown opcodes, then a misaligned distance that wins over a bad opcode
    add_jump(barp_pkg::MODE_BRANCH, 64'h0, 64'sd4, 32'h0000_0000);
    add_jump(barp_pkg::MODE_BRANCH, 64'h0, 64'sd4, 32'hffff_ffff);
    add_request(barp_pkg::MODE_BRANCH, 64'h100, 64'h102, 32'h0000_0000, 32'h0, 32'h0);
    // distance across the top of the address space
    add_request(barp_pkg::MODE_BRANCH, 64'hffff_ffff_ffff_fff0, 64'h10, barp_pkg::INSN_B,
                32'hffff_ffff, 32'hffff_ffff);
    // pc-relative upper part on both range edges
    add_jump(barp_pkg::MODE_PCREL, 64'h0000_0001_0000_0000, 64'sd34359705599, 32'hffff_ffff);
    add_jump(barp_pkg::MODE_PCREL, 64'h0000_0001_0000_0000, 64'sd34359705600, 32'hffff_ffff);
    add_jump(barp_pkg::MODE_PCREL, 64'h7fff_ffff_ffff_fffc, -64'sd34359771136, 32'h0);
    add_jump(barp_pkg::MODE_PCREL, 64'h7fff_ffff_ffff_fffc, -64'sd34359771137, 32'h0);
    add_request(barp_pkg::MODE_PCREL, 64'h1000, 64'h1001, 32'h0, 32'hffff_ffff,
                32'hffff_ffff);
    // absolute loads
    add_request(barp_pkg::MODE_ABS2, 64'h0, 64'h7fff_ffff,
                barp_pkg::INSN_LU12I_W | 32'h01ff_ffff,
                barp_pkg::INSN_ORI | 32'h003f_ffff, 32'hffff_ffff);
    add_request(barp_pkg::MODE_ABS2, 64'h0, 64'h8000_0000, barp_pkg::INSN_LU12I_W,
                barp_pkg::INSN_ORI, 32'h0);
    add_request(barp_pkg::MODE_ABS2, 64'h0, 64'hffff_ffff_ffff_ffff, barp_pkg::INSN_LU12I_W,
                barp_pkg::INSN_ORI, 32'h0);
    add_request(barp_pkg::MODE_ABS2, 64'h0, 64'h1234_5678, barp_pkg::INSN_LU12I_W,
                barp_pkg::INSN_ORI ^ 32'h0040_0000, 32'h0);
    add_request(barp_pkg::MODE_ABS3, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                barp_pkg::INSN_LU12I_W | 32'h01ff_ffff,
                barp_pkg::INSN_ORI | 32'h003f_ffff,
                barp_pkg::INSN_LU32I_D | 32'h01ff_ffff);
    add_request(barp_pkg::MODE_ABS3, 64'h0, 64'h000f_ffff_ffff_ffff, barp_pkg::INSN_LU12I_W,
                barp_pkg::INSN_ORI, barp_pkg::INSN_LU12I_W);
    add_request(barp_pkg::MODE_ABS3, 64'h0, 64'h0,
                barp_pkg::INSN_LU12I_W | 32'h01ff_ffff,
                barp_pkg::INSN_ORI | 32'h003f_ffff,
                barp_pkg::INSN_LU32I_D | 32'h01ff_ffff);
    repeat (2000) pending_requests.push_back(random_request());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_patches.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
